[design/covariance_kernel_eval_macros.svh]
// Assertion macros shared by the covariance kernel evaluator RTL.
// Included by files that carry assertions; no other dependencies.
`ifndef COVARIANCE_KERNEL_EVAL_MACROS_SVH
`define COVARIANCE_KERNEL_EVAL_MACROS_SVH

`ifndef SYNTHESIS

`define CKE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define CKE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define CKE_ASSERT(lbl, prop, msg)

`define CKE_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

[design/cke_pkg.sv]
// Package for the covariance kernel evaluator: widths, codes, stage types
// and the exponent table generator. No dependencies.
`default_nettype none

package cke_pkg;

  localparam int unsigned EXP_TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W             = $clog2(EXP_TABLE_ENTRIES);
  localparam int unsigned POS_W             = 16 + IDX_W;
  localparam int unsigned SERIES_TERMS      = 24;

  localparam int unsigned T_W = 23;
  localparam int unsigned U_W = 23;
  localparam int unsigned E_W = 33;
  localparam int unsigned K_W = 7;

  localparam logic [63:0]    LN2_Q32   = 64'd2977044472;
  localparam logic [32:0]    LOG2E_Q32 = 33'd6196328019;
  localparam logic [T_W-1:0] T_CLAMP   = T_W'(64 << 16);

  localparam logic [23:0] INV_LEN_RESET = 24'd65536;
  localparam logic [31:0] VARIANCE_RESET = 32'd65536;

  typedef enum logic [1:0] {
    CFG_KERNEL_KIND = 2'd0,
    CFG_INV_LENGTH  = 2'd1,
    CFG_SIGNAL_VAR  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_SQ_EXP = 1'b0,
    KIND_EXP    = 1'b1
  } kernel_kind_e;

  typedef struct packed {
    logic [T_W-1:0] t;
    logic [31:0]    noise;
  } dist_t;

  typedef struct packed {
    logic [E_W-1:0] e;
    logic [31:0]    noise;
  } scale_t;

  // 2^(-i/N) in Q1.32 via alternating series of exp(-a); elaboration only.
  function automatic logic [E_W-1:0] exp_tab_val(input int unsigned i);
    logic [63:0] a;
    logic [63:0] sum;
    logic [63:0] term;
    a    = (64'(i) * LN2_Q32) / 64'(EXP_TABLE_ENTRIES);
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * a) >> 32) / 64'(n);
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[E_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/cke_dist.sv]
// Distance front end: |x-y|, scaling by the length reciprocal, kernel
// argument t with clamping, noise square. Depends on cke_pkg.
`default_nettype none
`include "covariance_kernel_eval_macros.svh"

module cke_dist
  import cke_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kernel_kind_e        kind_i,
  input  wire logic [23:0]         inv_len_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic signed [31:0]  x_point_i,
  input  wire logic signed [31:0]  y_point_i,
  input  wire logic [23:0]         noise_sigma_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dist_t                    out_o
);

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic [32:0] diff;
  logic [32:0] ad_d, ad_q;
  logic [47:0] nsq_d, nsq_q;
  logic [56:0] rprod;
  logic [40:0] r_d, r_q;
  logic [31:0] noise_q;
  logic [47:0] sq;
  logic [30:0] sqs;
  logic [T_W-1:0] t_d;
  dist_t          out_q;

  assign rdy[2]     = !vld_q[2] || out_ready_i;
  assign rdy[1]     = !vld_q[1] || rdy[2];
  assign rdy[0]     = !vld_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  assign diff  = {x_point_i[31], x_point_i} - {y_point_i[31], y_point_i};
  assign ad_d  = diff[32] ? (~diff + 33'd1) : diff;
  assign nsq_d = noise_sigma_i * noise_sigma_i;

  assign rprod = 57'(ad_q) * 57'(inv_len_i);
  assign r_d   = rprod[56:16];

  assign sq  = r_q[23:0] * r_q[23:0];
  assign sqs = sq[47:17];

  always_comb begin
    if (kind_i == KIND_SQ_EXP) begin
      if (|r_q[40:24]) begin
        t_d = T_CLAMP;
      end else if (sqs > 31'(T_CLAMP)) begin
        t_d = T_CLAMP;
      end else begin
        t_d = sqs[T_W-1:0];
      end
    end else begin
      if (r_q > 41'(T_CLAMP)) begin
        t_d = T_CLAMP;
      end else begin
        t_d = r_q[T_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ad_q  <= ad_d;
      nsq_q <= nsq_d;
    end
    if (rdy[1]) begin
      r_q     <= r_d;
      noise_q <= nsq_q[47:16];
    end
    if (rdy[2]) begin
      out_q.t     <= t_d;
      out_q.noise <= noise_q;
    end
  end

  assign out_valid_o = vld_q[2];
  assign out_o       = out_q;

  `CKE_ASSERT_IMPL(a_t_clamped, vld_q[2], out_q.t <= T_CLAMP, "t above clamp")
  `CKE_ASSERT(a_dist_hold, vld_q[2] && !out_ready_i |=> vld_q[2], "stalled item lost")

endmodule

`default_nettype wire

[design/cke_exp.sv]
// Exponent back end: t*log2(e), table lookup with linear interpolation,
// integer power as a right shift. Depends on cke_pkg.
`default_nettype none
`include "covariance_kernel_eval_macros.svh"

module cke_exp
  import cke_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire dist_t in_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output scale_t     out_o
);

  logic [E_W-1:0] tab_lo [EXP_TABLE_ENTRIES];
  logic [E_W-1:0] tab_hi [EXP_TABLE_ENTRIES];

  for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_tab
    localparam logic [E_W-1:0] LO = exp_tab_val(g);
    localparam logic [E_W-1:0] HI = exp_tab_val(g + 1);
    assign tab_lo[g] = LO;
    assign tab_hi[g] = HI;
  end

  logic [3:0] vld_q;
  logic [3:0] rdy;

  logic [55:0]      uprod;
  logic [U_W-1:0]   u_q;
  logic [31:0]      noise4_q, noise5_q, noise6_q;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic [K_W-1:0]   k5_q, k6_q;
  logic [15:0]      w_q;
  logic [E_W-1:0]   e0_q, e1_q;
  logic [E_W-1:0]   ediff;
  logic [48:0]      iprod;
  logic [E_W-1:0]   ei_q;
  scale_t           out_q;

  assign rdy[3]     = !vld_q[3] || out_ready_i;
  assign rdy[2]     = !vld_q[2] || rdy[3];
  assign rdy[1]     = !vld_q[1] || rdy[2];
  assign rdy[0]     = !vld_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  assign uprod = 56'(in_i.t) * 56'(LOG2E_Q32);

  assign pos = POS_W'(u_q[15:0]) * POS_W'(EXP_TABLE_ENTRIES);
  assign idx = pos[POS_W-1:16];

  assign ediff = e0_q - e1_q;
  assign iprod = 49'(ediff) * 49'(w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      u_q      <= uprod[54:32];
      noise4_q <= in_i.noise;
    end
    if (rdy[1]) begin
      k5_q     <= K_W'(u_q[U_W-1:16]);
      w_q      <= pos[15:0];
      e0_q     <= tab_lo[idx];
      e1_q     <= tab_hi[idx];
      noise5_q <= noise4_q;
    end
    if (rdy[2]) begin
      k6_q     <= k5_q;
      ei_q     <= e0_q - iprod[48:16];
      noise6_q <= noise5_q;
    end
    if (rdy[3]) begin
      // shifts of 33 or more clear the value, covering the k >= 64 case
      out_q.e     <= ei_q >> k6_q;
      out_q.noise <= noise6_q;
    end
  end

  assign out_valid_o = vld_q[3];
  assign out_o       = out_q;

  `CKE_ASSERT_IMPL(a_e_range, vld_q[3], out_q.e <= E_W'(64'd1 << 32), "exp above one")

endmodule

`default_nettype wire

[design/covariance_kernel_eval.sv]
// Covariance kernel evaluator, top level: configuration registers, variance
// scaling, noise add and saturation. Depends on cke_pkg, cke_dist, cke_exp.
// Throughput: one item per cycle while out_stall_i is low; each of the nine stages holds one item.
// A stall holds only the stages that are full; bubbles close up.
// Reset clears all stage valid bits and loads the register defaults.
`default_nettype none
`include "covariance_kernel_eval_macros.svh"

module covariance_kernel_eval
  import cke_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_addr_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] x_point_i,
  input  wire logic signed [31:0] y_point_i,
  input  wire logic [23:0]        noise_sigma_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [31:0]             cov_value_o,
  output logic                    saturated_o
);

  kernel_kind_e kind_q;
  logic [23:0]  inv_len_q;
  logic [31:0]  var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_SQ_EXP;
      inv_len_q <= INV_LEN_RESET;
      var_q     <= VARIANCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_KERNEL_KIND: kind_q    <= kernel_kind_e'(cfg_wdata_i[0]);
        CFG_INV_LENGTH:  inv_len_q <= cfg_wdata_i[23:0];
        CFG_SIGNAL_VAR:  var_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic   dist_valid, dist_ready, in_ready;
  dist_t  dist_item;
  logic   exp_valid, exp_ready;
  scale_t scl;

  cke_dist u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_q),
    .inv_len_i     (inv_len_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready),
    .x_point_i     (x_point_i),
    .y_point_i     (y_point_i),
    .noise_sigma_i (noise_sigma_i),
    .out_valid_o   (dist_valid),
    .out_ready_i   (dist_ready),
    .out_o         (dist_item)
  );

  cke_exp u_exp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dist_valid),
    .in_ready_o  (dist_ready),
    .in_i        (dist_item),
    .out_valid_o (exp_valid),
    .out_ready_i (exp_ready),
    .out_o       (scl)
  );

  assign in_stall_o = !in_ready;

  logic [1:0]  vld_q;
  logic [1:0]  rdy;
  logic [64:0] kprod;
  logic [31:0] kern_q, noise_q;
  logic [32:0] sum;
  logic [31:0] cov_q;
  logic        sat_q;

  assign rdy[1]    = !vld_q[1] || !out_stall_i;
  assign rdy[0]    = !vld_q[0] || rdy[1];
  assign exp_ready = rdy[0];

  assign kprod = 65'(var_q) * 65'(scl.e);
  assign sum   = {1'b0, kern_q} + {1'b0, noise_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= exp_valid;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      kern_q  <= kprod[63:32];
      noise_q <= scl.noise;
    end
    if (rdy[1]) begin
      cov_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      sat_q <= sum[32];
    end
  end

  assign out_valid_o = vld_q[1];
  assign cov_value_o = cov_q;
  assign saturated_o = sat_q;

  `CKE_ASSERT_IMPL(a_sat_max, out_valid_o && saturated_o, cov_value_o == 32'hFFFF_FFFF, "sat")
  `CKE_ASSERT_IMPL(a_empty_ready, !out_valid_o, !in_stall_o, "stall with empty output")

endmodule

`default_nettype wire
